// File: rtl/core/lfsr_frame_descrambler_unit_assert.svh
// Assertion macros used by the descrambler core RTL
// Needs a clock named clk and a synchronous reset named rst in the including module
`ifndef LFSR_FRAME_DESCRAMBLER_UNIT_ASSERT_SVH
`define LFSR_FRAME_DESCRAMBLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfd assertion failed");

// next-cycle implication, disabled during reset
`define LFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfd assertion failed");

`endif

// File: rtl/core/lfd_pkg.sv
// Package for the LFSR frame descrambler: payload types, codes, constants, key step
// No dependencies
`timescale 1ns / 1ps

package lfd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 255;
  localparam logic [31:0] KEY_SEED_RST = 32'hdfd109e8;
  localparam logic [7:0] MARKER_RST = 8'h4b;
  localparam logic [7:0] PAYLOAD_START = 8'd15;
  localparam logic [7:0] MIN_FRAME_BYTES = 8'd16;
  localparam logic [7:0] HDR_FIRST = 8'd2;
  localparam logic [7:0] HDR_LAST = 8'd13;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER = 1'd1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_SHORT = 2'd1,
    ST_MARKER = 2'd2,
    ST_LONG = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic data_valid;
    logic frame_end;
    logic [1:0] frame_status;
    logic [7:0] payload_count;
  } result_t;

  typedef struct packed {
    logic [31:0] key_seed;
    logic [7:0] expected_marker;
  } cfg_t;

  // eight shifts of the key lfsr, feedback from bits 1, 2, 11 and 31 into bit 0
  function automatic logic [31:0] lfsr_byte_step(input logic [31:0] k);
    logic [31:0] s;
    s = k;
    for (int i = 0; i < 8; i++) begin
      s = {s[30:0], s[1] ^ s[2] ^ s[11] ^ s[31]};
    end
    return s;
  endfunction

endpackage

// File: rtl/core/lfd_cfg_regs.sv
// Configuration registers of the descrambler: key seed and expected marker
// Depends on lfd_pkg
`timescale 1ns / 1ps

module lfd_cfg_regs import lfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [31:0] wr_data,
  output cfg_t cfg
);

  // register writes, decoded by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_seed <= KEY_SEED_RST;
      cfg.expected_marker <= MARKER_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_KEY_SEED: cfg.key_seed <= wr_data;
        REG_MARKER: cfg.expected_marker <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/lfd_core.sv
// Descrambler datapath: input register, frame state and key update, result build
// Depends on lfd_pkg and lfsr_frame_descrambler_unit_assert.svh
`timescale 1ns / 1ps
`include "lfsr_frame_descrambler_unit_assert.svh"

module lfd_core import lfd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  in_item_t item,
  input  cfg_t cfg,
  output logic push,
  output result_t push_data,
  input  logic push_ready
);

  localparam logic [7:0] MaxPos = 8'(MAX_FRAME_BYTES);

  in_item_t item_q;
  logic item_full;
  logic [7:0] pos;
  logic [31:0] key;
  logic marker_ok;
  logic overflow_seen;

  logic over;
  logic [31:0] key_base;
  logic [31:0] key_hdr;
  logic [31:0] key_pay;
  logic [31:0] key_next;
  logic [1:0] hdr_off;
  logic [7:0] dec;
  logic payload;
  logic [7:0] pos_next;
  logic marker_next;
  logic ovf_next;
  logic emit;
  logic advance;
  frame_status_t status;
  logic [7:0] count;

  // byte classification and key update
  always_comb begin
    over = (pos >= MaxPos);
    key_base = (pos == 8'd0) ? cfg.key_seed : key;
    hdr_off = pos[1:0] - HDR_FIRST[1:0];
    case (hdr_off)
      2'd0: key_hdr = key_base ^ {item_q.in_byte, 24'd0};
      2'd1: key_hdr = key_base ^ {8'd0, item_q.in_byte, 16'd0};
      2'd2: key_hdr = key_base ^ {16'd0, item_q.in_byte, 8'd0};
      2'd3: key_hdr = key_base ^ {24'd0, item_q.in_byte};
      default: key_hdr = key_base;
    endcase
    key_pay = lfsr_byte_step(key_base);
    payload = !over && (pos >= PAYLOAD_START);
    dec = payload ? (item_q.in_byte ^ key_pay[7:0]) : 8'd0;
    if (over) begin
      key_next = key;
    end else if (pos >= HDR_FIRST && pos <= HDR_LAST) begin
      key_next = key_hdr;
    end else if (payload) begin
      key_next = key_pay;
    end else begin
      key_next = key_base;
    end
    pos_next = over ? pos : pos + 8'd1;
    ovf_next = overflow_seen || over;
    marker_next = (!over && pos == PAYLOAD_START) ? (dec == cfg.expected_marker)
                                                  : marker_ok;
  end

  // closing status, too-long frame first, then short, then bad marker
  always_comb begin
    count = 8'd0;
    if (pos_next < MIN_FRAME_BYTES && !ovf_next) begin
      status = ST_SHORT;
    end else if (ovf_next) begin
      status = ST_LONG;
    end else if (!marker_next) begin
      status = ST_MARKER;
    end else begin
      status = ST_OK;
      count = pos_next - PAYLOAD_START;
    end
  end

  // result build and handshake
  always_comb begin
    emit = payload || item_q.last_byte;
    push = item_full && emit;
    advance = item_full && (!emit || push_ready);
    item_ready = !item_full || advance;
    push_data.out_byte = dec;
    push_data.data_valid = payload;
    push_data.frame_end = item_q.last_byte;
    push_data.frame_status = item_q.last_byte ? status : ST_OK;
    push_data.payload_count = item_q.last_byte ? count : 8'd0;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_ready) begin
      item_full <= item_valid;
    end
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  // frame state; position, marker and overflow flags are cleared by the closing byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 8'd0;
      key <= 32'd0;
      marker_ok <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (advance) begin
      key <= key_next;
      if (item_q.last_byte) begin
        pos <= 8'd0;
        marker_ok <= 1'b0;
        overflow_seen <= 1'b0;
      end else begin
        pos <= pos_next;
        marker_ok <= marker_next;
        overflow_seen <= ovf_next;
      end
    end
  end

  // position never runs past the frame limit
  `LFD_ASSERT_NOW(a_pos_limit, 1'b1, pos <= MaxPos)
  // a closing transaction starts the next frame at byte zero
  `LFD_ASSERT_NEXT(a_frame_restart, advance && item_q.last_byte, pos == 8'd0)
  // an in-range non-closing byte moves the position by one
  `LFD_ASSERT_NEXT(a_pos_step, advance && !item_q.last_byte && pos < MaxPos,
                   pos == $past(pos) + 8'd1)
  // too-long status only after the limit was reached
  `LFD_ASSERT_NOW(a_long_cause, push && push_data.frame_status == ST_LONG,
                  pos == MaxPos)

endmodule

// File: rtl/core/lfd_out_reg.sv
// Result register of the descrambler, holds one result until it is taken
// Depends on lfd_pkg
`timescale 1ns / 1ps

module lfd_out_reg import lfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  result_t push_data,
  output logic push_ready,
  output logic result_valid,
  input  logic result_ready,
  output result_t result
);

  assign push_ready = !result_valid || result_ready;

  // load a new result when the slot is free or being emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push_ready) begin
      result_valid <= push;
    end
    if (push_ready && push) begin
      result <= push_data;
    end
  end

endmodule

// File: rtl/core/lfsr_frame_descrambler_unit.sv
// channel   | signals                                  | role
// item      | item_valid, item_ready, item             | frame bytes in, last flag
// result    | result_valid, result_ready, result       | payload bytes and frame close
// config    | wr_en, wr_index, wr_data                 | key seed, expected marker
//
// one byte per cycle unless results stall; each byte waits in the input register,
// where the key update (eight lfsr shifts, flattened) and status are computed, and
// then sits in the result register; header bytes that close nothing leave no result
// rst is synchronous; it clears the frame state and restores the register defaults
// a stalled result holds in the result register while the next byte is worked on
// Top level; depends on lfd_pkg, lfd_cfg_regs, lfd_core, lfd_out_reg
`timescale 1ns / 1ps

module lfsr_frame_descrambler_unit import lfd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  in_item_t item,
  output logic result_valid,
  input  logic result_ready,
  output result_t result,
  input  logic wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [31:0] wr_data
);

  cfg_t cfg;
  logic push;
  logic push_ready;
  result_t push_data;

  // configuration registers
  lfd_cfg_regs u_cfg (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .cfg(cfg)
  );

  // descrambling datapath
  lfd_core #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_core (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .cfg(cfg),
    .push(push),
    .push_data(push_data),
    .push_ready(push_ready)
  );

  // output register
  lfd_out_reg u_out (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .push_ready(push_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

endmodule
